[rtl/gnc_pkg.sv]
`default_nettype none

package gnc_pkg;

    localparam int CFG_W     = 11;
    localparam int ROW_W     = 11;
    localparam int POS_W     = 10;
    localparam int DIGIT_W   = 6;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_ROWS   = 1024;
    localparam int RESET_ROWS = 16;
    localparam int RESET_COLS = 16;

    localparam logic [CHAR_W-1:0]  MINE_CHAR  = 8'd33;
    localparam logic [DIGIT_W-1:0] DIGIT_BASE = 6'd48;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 6'd57;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic drain;
        logic mine;
    } t_step;

    typedef struct packed {
        logic  valid;
        t_step step;
    } t_push;

    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic             restart;
    } t_grid;

endpackage

`default_nettype wire

[rtl/gnc_if.sv]
`default_nettype none

interface gnc_cell_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [gnc_pkg::CHAR_W-1:0]  cell_char;

    modport source (output valid, output opcode, output cell_char, input ready);
    modport sink   (input valid, input opcode, input cell_char, output ready);
endinterface

interface gnc_result_if;
    logic                        valid;
    logic                        ready;
    logic [gnc_pkg::DIGIT_W-1:0] digit_char;
    logic [gnc_pkg::POS_W-1:0]   cell_row;
    logic [gnc_pkg::POS_W-1:0]   cell_col;
    logic                        last_cell;

    modport source (output valid, output digit_char, output cell_row, output cell_col,
                    output last_cell, input ready);
    modport sink   (input valid, input digit_char, input cell_row, input cell_col,
                    input last_cell, output ready);
endinterface

interface gnc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gnc_pkg::CFG_IDX_W-1:0] index;
    logic [gnc_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/grid_3x3_neighbor_count.sv]
// a window's result goes through the queue, the x stage and the output register to o_result
// throughput: one transaction per cycle unless o_result stalls; the line store is read each step
// a drain on a grid under one row plus one cell steps blank cells until that many are stepped
// reset: synchronous active-low i_rst_n clears control state and loads 16 rows and 16 columns
// the line store has no reset; an entry read before it is written feeds only masked edge bits
`default_nettype none

module grid_3x3_neighbor_count #(
    parameter int MAX_COLS = 1024
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gnc_cell_if.sink     i_cell,
    gnc_cfg_if.sink      i_cfg,
    gnc_result_if.source o_result
);

    gnc_pkg::t_push w_push;
    gnc_pkg::t_push w_head;
    gnc_pkg::t_grid w_grid;
    logic           w_q_full;
    logic           w_pop;

    gnc_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (i_cell),
        .i_cfg    (i_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_grid   (w_grid)
    );

    gnc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    gnc_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_grid   (w_grid),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.digit_char >= gnc_pkg::DIGIT_BASE)
                        && (o_result.digit_char <= gnc_pkg::DIGIT_MAX))
        else $error("digit out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_q_full)
        else $error("queue written while full");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue read while empty");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.last_cell)
            |-> (o_result.cell_col == gnc_pkg::POS_W'(w_grid.cols - 1'b1))
             && (o_result.cell_row == gnc_pkg::POS_W'(w_grid.rows - 1'b1)))
        else $error("last cell flag away from the final position");

endmodule

`default_nettype wire

[rtl/gnc_front.sv]
`default_nettype none

module gnc_front #(
    parameter int MAX_COLS = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    gnc_cell_if.sink       i_cell,
    gnc_cfg_if.sink        i_cfg,
    input  wire logic      i_q_full,
    output gnc_pkg::t_push o_push,
    output gnc_pkg::t_grid o_grid
);

    localparam int CW       = $clog2(MAX_COLS);
    localparam int LW       = (CW > gnc_pkg::CFG_W) ? CW : gnc_pkg::CFG_W;
    localparam int RST_COLS = (gnc_pkg::RESET_COLS > MAX_COLS) ? MAX_COLS : gnc_pkg::RESET_COLS;
    localparam int RST_ROWS = (gnc_pkg::RESET_ROWS > gnc_pkg::MAX_ROWS) ?
                              gnc_pkg::MAX_ROWS : gnc_pkg::RESET_ROWS;

    logic [gnc_pkg::CFG_W-1:0] r_rows, n_rows;
    logic [gnc_pkg::CFG_W-1:0] r_cols, n_cols;
    logic [gnc_pkg::ROW_W-1:0] r_f_row, n_f_row;
    logic [CW-1:0]             r_f_col, n_f_col;

    logic accept;
    logic cfg_wr;
    logic feed_done;
    logic is_cell;
    logic is_drain;
    logic col_last;

    assign i_cell.ready = !i_q_full;
    assign i_cfg.ready  = 1'b1;

    assign accept    = i_cell.valid && i_cell.ready;
    assign cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign feed_done = (r_f_row >= r_rows);
    assign is_cell   = (i_cell.opcode == gnc_pkg::OP_CELL) && !feed_done;
    assign is_drain  = (i_cell.opcode == gnc_pkg::OP_DRAIN) && feed_done;
    assign col_last  = (LW'(r_f_col) == LW'(r_cols - 1'b1));

    // cells past the grid and early drains never reach the queue
    always_comb begin
        o_push.valid      = accept && (is_cell || is_drain);
        o_push.step.drain = is_drain;
        o_push.step.mine  = is_cell && (i_cell.cell_char == gnc_pkg::MINE_CHAR);
    end

    always_comb begin
        o_grid.rows    = r_rows;
        o_grid.cols    = r_cols;
        o_grid.restart = cfg_wr;
    end

    always_comb begin
        n_rows  = r_rows;
        n_cols  = r_cols;
        n_f_row = r_f_row;
        n_f_col = r_f_col;
        if (cfg_wr) begin
            case (i_cfg.index)
                gnc_pkg::REG_GRID_ROWS: begin
                    if (i_cfg.data == '0) begin
                        n_rows = gnc_pkg::CFG_W'(1);
                    end else if (32'(i_cfg.data) > gnc_pkg::MAX_ROWS) begin
                        n_rows = gnc_pkg::CFG_W'(gnc_pkg::MAX_ROWS);
                    end else begin
                        n_rows = i_cfg.data;
                    end
                end
                gnc_pkg::REG_GRID_COLS: begin
                    if (i_cfg.data == '0) begin
                        n_cols = gnc_pkg::CFG_W'(1);
                    end else if (32'(i_cfg.data) > MAX_COLS) begin
                        n_cols = gnc_pkg::CFG_W'(MAX_COLS);
                    end else begin
                        n_cols = i_cfg.data;
                    end
                end
                default: begin
                end
            endcase
            n_f_row = '0;
            n_f_col = '0;
        end else if (accept && is_cell) begin
            if (col_last) begin
                n_f_col = '0;
                n_f_row = r_f_row + 1'b1;
            end else begin
                n_f_col = r_f_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= gnc_pkg::CFG_W'(RST_ROWS);
            r_cols  <= gnc_pkg::CFG_W'(RST_COLS);
            r_f_row <= '0;
            r_f_col <= '0;
        end else begin
            r_rows  <= n_rows;
            r_cols  <= n_cols;
            r_f_row <= n_f_row;
            r_f_col <= n_f_col;
        end
    end

endmodule

`default_nettype wire

[rtl/gnc_queue.sv]
`default_nettype none

module gnc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gnc_pkg::t_push i_push,
    input  wire logic           i_pop,
    output logic                o_full,
    output gnc_pkg::t_push      o_head
);

    gnc_pkg::t_step               r_mem [gnc_pkg::Q_DEPTH];
    logic [gnc_pkg::Q_AW-1:0]     r_wr_ptr;
    logic [gnc_pkg::Q_AW-1:0]     r_rd_ptr;
    logic [gnc_pkg::Q_AW:0]       r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (gnc_pkg::Q_AW+1)'(gnc_pkg::Q_DEPTH));
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        o_head.valid = (r_count != '0);
        o_head.step  = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/gnc_back.sv]
`default_nettype none

module gnc_back #(
    parameter int MAX_COLS = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gnc_pkg::t_grid i_grid,
    input  wire gnc_pkg::t_push i_head,
    output logic                o_pop,
    gnc_result_if.source        o_result
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int LW = (CW > gnc_pkg::CFG_W) ? CW : gnc_pkg::CFG_W;

    // line store: [1] two rows up, [0] one row up
    logic [1:0]                r_store [MAX_COLS];
    logic [1:0]                r_rd_data;

    logic [CW-1:0]             r_s_col;
    logic [1:0]                r_s_ph;
    logic [gnc_pkg::ROW_W-1:0] r_e_row;
    logic [CW-1:0]             r_e_col;

    logic                      r_x_valid;
    logic                      r_x_emit;
    logic                      r_x_mine;
    logic [CW-1:0]             r_x_addr;
    logic                      r_x_fwd;
    logic [1:0]                r_x_fwd_data;
    logic                      r_x_top;
    logic                      r_x_bot;
    logic                      r_x_left;
    logic                      r_x_right;
    logic                      r_x_last;
    logic [gnc_pkg::POS_W-1:0] r_x_row;
    logic [gnc_pkg::POS_W-1:0] r_x_col;

    // window columns: [0] top, [1] middle, [2] bottom
    logic [2:0]                r_win_l;
    logic [2:0]                r_win_c;

    logic                        r_out_valid;
    logic [gnc_pkg::DIGIT_W-1:0] r_out_digit;
    logic [gnc_pkg::POS_W-1:0]   r_out_row;
    logic [gnc_pkg::POS_W-1:0]   r_out_col;
    logic                        r_out_last;

    logic       a_can;
    logic       gate;
    logic       emit_done;
    logic       step_go;
    logic       a_emit;
    logic       a_mine;
    logic       s_col_last;
    logic       e_col_last;
    logic       e_row_last;

    logic       out_can;
    logic       x_done;
    logic [1:0] x_rd;
    logic [2:0] x_vec;
    logic [1:0] x_wr_data;
    logic [2:0] x_win [3];
    logic [2:0] x_colen;
    logic [3:0] x_cnt;

    assign out_can = !r_out_valid || o_result.ready;
    assign x_done  = r_x_valid && (!r_x_emit || out_can);
    assign a_can   = !r_x_valid || x_done;

    assign gate       = (r_s_ph == 2'd2) || ((r_s_ph == 2'd1) && (r_s_col != '0));
    assign emit_done  = (r_e_row >= i_grid.rows);
    assign s_col_last = (LW'(r_s_col) == LW'(i_grid.cols - 1'b1));
    assign e_col_last = (LW'(r_e_col) == LW'(i_grid.cols - 1'b1));
    assign e_row_last = (r_e_row == (i_grid.rows - 1'b1));

    // drains past the end of a short grid first step blank cells until a window is due
    always_comb begin
        o_pop   = 1'b0;
        step_go = 1'b0;
        a_emit  = 1'b0;
        a_mine  = 1'b0;
        if (i_head.valid && a_can) begin
            if (!i_head.step.drain) begin
                o_pop   = 1'b1;
                step_go = 1'b1;
                a_emit  = gate && !emit_done;
                a_mine  = i_head.step.mine;
            end else if (emit_done) begin
                o_pop = 1'b1;
            end else if (!gate) begin
                step_go = 1'b1;
            end else begin
                o_pop   = 1'b1;
                step_go = 1'b1;
                a_emit  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_rd_data <= r_store[r_s_col];
        end
        if (x_done) begin
            r_store[r_x_addr] <= x_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_col <= '0;
            r_s_ph  <= '0;
            r_e_row <= '0;
            r_e_col <= '0;
        end else if (i_grid.restart) begin
            r_s_col <= '0;
            r_s_ph  <= '0;
            r_e_row <= '0;
            r_e_col <= '0;
        end else begin
            if (step_go) begin
                if (s_col_last) begin
                    r_s_col <= '0;
                    if (r_s_ph != 2'd2) begin
                        r_s_ph <= r_s_ph + 1'b1;
                    end
                end else begin
                    r_s_col <= r_s_col + 1'b1;
                end
            end
            if (a_emit) begin
                if (e_col_last) begin
                    r_e_col <= '0;
                    r_e_row <= r_e_row + 1'b1;
                end else begin
                    r_e_col <= r_e_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (a_can) begin
            r_x_valid <= step_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_x_emit     <= a_emit;
            r_x_mine     <= a_mine;
            r_x_addr     <= r_s_col;
            r_x_fwd      <= r_x_valid && (r_x_addr == r_s_col);
            r_x_fwd_data <= x_wr_data;
            r_x_top      <= (r_e_row != '0);
            r_x_bot      <= !e_row_last;
            r_x_left     <= (r_e_col != '0);
            r_x_right    <= !e_col_last;
            r_x_last     <= e_row_last && e_col_last;
            r_x_row      <= gnc_pkg::POS_W'(r_e_row);
            r_x_col      <= gnc_pkg::POS_W'(r_e_col);
        end
    end

    assign x_rd      = r_x_fwd ? r_x_fwd_data : r_rd_data;
    assign x_vec     = {r_x_mine, x_rd[0], x_rd[1]};
    assign x_wr_data = {x_rd[0], r_x_mine};

    always_comb begin
        x_win[0] = r_win_l;
        x_win[1] = r_win_c;
        x_win[2] = x_vec;
        x_colen  = {r_x_right, 1'b1, r_x_left};
        x_cnt    = '0;
        for (int k = 0; k < 3; k++) begin
            if (x_colen[k]) begin
                x_cnt = x_cnt + 4'(x_win[k][0] & r_x_top) + 4'(x_win[k][1])
                      + 4'(x_win[k][2] & r_x_bot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_l <= '0;
            r_win_c <= '0;
        end else if (x_done) begin
            r_win_l <= r_win_c;
            r_win_c <= x_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_can) begin
            r_out_valid <= r_x_valid && r_x_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_done && r_x_emit) begin
            r_out_digit <= gnc_pkg::DIGIT_BASE + gnc_pkg::DIGIT_W'(x_cnt);
            r_out_row   <= r_x_row;
            r_out_col   <= r_x_col;
            r_out_last  <= r_x_last;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.digit_char = r_out_digit;
    assign o_result.cell_row   = r_out_row;
    assign o_result.cell_col   = r_out_col;
    assign o_result.last_cell  = r_out_last;

endmodule

`default_nettype wire
